// ----- design/usc_pkg.sv -----
// Constants and the month-length table for the Unix seconds to calendar converter.
// No dependencies; used by unix_seconds_to_calendar_unit.
package usc_pkg;

  localparam int unsigned SecsTo2000  = 946684800;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysPerQuad = 1461;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned BaseYear    = 2000;
  localparam int unsigned LastMonth   = 12;

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- design/unix_seconds_to_calendar_unit.sv -----
// Unix seconds to calendar converter: one shared subtract-and-compare unit under a sequencer.
// Depends on usc_pkg for constants and the month-length table.
//
// Channel   Handshake                  Payload
// item      item_valid / item_stall    unix_seconds
// result    result_valid / result_stall year, month, day, hour, minute, second, before_epoch
//
// A time before 2000 skips the four-year split and the year and month walks.
// The single 32-bit subtractor gives one quotient bit per cycle for the day, hour, minute
// and four-year splits, then one year or one month per cycle in the walks.
// The input stalls from a transfer until its result is written, so no new timestamp is taken
// before then; a result still held off by result_stall delays the next transfer by the hold-off.
// Reset is synchronous and clears the sequencer and the result valid flag.
module unix_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] unix_seconds,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        before_epoch
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DAYS, S_HOUR, S_MIN, S_QUAD, S_YEAR, S_MON, S_DONE
  } state_t;

  state_t      state;
  logic [31:0] acc;
  logic [3:0]  k;
  logic [15:0] q;
  logic [15:0] days;
  logic [4:0]  hour_w;
  logic [5:0]  minute_w;
  logic [5:0]  second_w;
  logic [4:0]  day_w;
  logic [7:0]  yoff;
  logic [3:0]  mon;
  logic        leap;
  logic        early;

  logic [31:0] opnd;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] acc_sub;
  logic [15:0] q_next;
  logic        leap_now;
  logic [8:0]  ylen;
  logic        out_free;

  assign leap_now = (yoff[1:0] == 2'd0);
  assign ylen     = leap_now ? 9'(usc_pkg::DaysPerYear + 1) : 9'(usc_pkg::DaysPerYear);

  always_comb begin
    unique case (state)
      S_PREP:  opnd = 32'(usc_pkg::SecsTo2000);
      S_DAYS:  opnd = 32'(usc_pkg::SecsPerDay) << k;
      S_HOUR:  opnd = 32'(usc_pkg::SecsPerHour) << k;
      S_MIN:   opnd = 32'(usc_pkg::SecsPerMin) << k;
      S_QUAD:  opnd = 32'(usc_pkg::DaysPerQuad) << k;
      S_YEAR:  opnd = {23'd0, ylen};
      S_MON:   opnd = {27'd0, usc_pkg::month_days(mon, leap)};
      default: opnd = 32'd0;
    endcase
  end

  assign diff     = {1'b0, acc} - {1'b0, opnd};
  assign ge       = ~diff[32];
  assign acc_sub  = ge ? diff[31:0] : acc;
  assign q_next   = {q[14:0], ge};
  assign out_free = ~result_valid | ~result_stall;

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            acc   <= unix_seconds;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          early <= ~ge;
          acc   <= acc_sub;
          k     <= 4'd15;
          state <= S_DAYS;
        end
        S_DAYS: begin
          acc <= acc_sub;
          q   <= q_next;
          if (k == 4'd0) begin
            days  <= q_next;
            k     <= 4'd4;
            state <= S_HOUR;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_HOUR: begin
          acc <= acc_sub;
          q   <= q_next;
          if (k == 4'd0) begin
            hour_w <= q_next[4:0];
            k      <= 4'd5;
            state  <= S_MIN;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_MIN: begin
          q <= q_next;
          if (k == 4'd0) begin
            minute_w <= q_next[5:0];
            second_w <= acc_sub[5:0];
            acc      <= {16'd0, days};
            k        <= 4'd5;
            state    <= early ? S_DONE : S_QUAD;
          end else begin
            acc <= acc_sub;
            k   <= k - 4'd1;
          end
        end
        S_QUAD: begin
          acc <= acc_sub;
          q   <= q_next;
          k   <= k - 4'd1;
          if (k == 4'd0) begin
            yoff  <= {q_next[5:0], 2'b00};
            state <= S_YEAR;
          end
        end
        S_YEAR: begin
          if (ge) begin
            acc  <= diff[31:0];
            yoff <= yoff + 8'd1;
          end else begin
            leap  <= leap_now;
            mon   <= 4'd1;
            state <= S_MON;
          end
        end
        S_MON: begin
          if (ge && (mon < 4'(usc_pkg::LastMonth))) begin
            acc <= diff[31:0];
            mon <= mon + 4'd1;
          end else begin
            day_w <= acc[4:0] + 5'd1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            year         <= early ? 12'd0 : 12'(usc_pkg::BaseYear) + {4'd0, yoff};
            month        <= early ? 4'd0 : mon;
            day          <= early ? 5'd0 : day_w;
            hour         <= hour_w;
            minute       <= minute_w;
            second       <= second_w;
            before_epoch <= early;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == S_PREP)
    else $error("Accepted item did not start the sequencer.");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !before_epoch |->
      month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && year >= 12'd2000)
    else $error("Date fields out of range.");

  a_early_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && before_epoch |-> year == 12'd0 && month == 4'd0 && day == 5'd0)
    else $error("Date fields not cleared for a time before 2000.");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> hour < 5'd24 && minute < 6'd60 && second < 6'd60)
    else $error("Time of day out of range.");
`endif

endmodule

// ----- sim/unix_seconds_to_calendar_check.sv -----
`timescale 1ns / 100ps
// Checker for unix_seconds_to_calendar_unit: it watches both channels, works out the calendar
// date of each input transfer and compares it with each result transfer.
// Depends on usc_pkg for the epoch and time-unit constants.
module unix_seconds_to_calendar_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [31:0] unix_seconds,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  input  logic        before_epoch,
  output int unsigned failures,
  output int unsigned pending
);

  typedef struct packed {
    logic [31:0] secs;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        before_epoch;
  } calendar_t;

  localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned HoursPerDay = 24;

  calendar_t   expected_dates [$];
  int unsigned fail_total = 0;

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    logic [31:0] rest;
    int unsigned days;
    int unsigned year_off;
    int unsigned mon;
    int unsigned mon_len;
    logic        leap;
    c = '0;
    c.secs = secs;
    c.before_epoch = secs < usc_pkg::SecsTo2000;
    rest = c.before_epoch ? secs : secs - usc_pkg::SecsTo2000;
    c.second = 6'(rest % usc_pkg::SecsPerMin);
    rest = rest / usc_pkg::SecsPerMin;
    c.minute = 6'(rest % usc_pkg::SecsPerMin);
    rest = rest / usc_pkg::SecsPerMin;
    c.hour = 5'(rest % HoursPerDay);
    days = rest / HoursPerDay;
    if (!c.before_epoch) begin
      year_off = 0;
      leap = 1'b1;
      while (days >= usc_pkg::DaysPerYear + leap) begin
        days = days - (usc_pkg::DaysPerYear + leap);
        year_off++;
        leap = (year_off % 4) == 0;
      end
      mon = 1;
      mon_len = MonthLen[0];
      while (mon < usc_pkg::LastMonth && days >= mon_len) begin
        days = days - mon_len;
        mon++;
        mon_len = MonthLen[mon - 1] + ((leap && mon == 2) ? 1 : 0);
      end
      c.year  = 12'(usc_pkg::BaseYear + year_off);
      c.month = 4'(mon);
      c.day   = 5'(days + 1);
    end
    return c;
  endfunction

  task automatic note_failure(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fail_total++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want,
                             input logic [31:0] secs);
    if (got != want) begin
      note_failure($sformatf("%s for %0d is %0d, want %0d", name, secs, got, want));
    end
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        expected_dates.push_back(calendar_of(unix_seconds));
      end
      if (result_valid && !result_stall) begin
        if (expected_dates.size() == 0) begin
          note_failure($sformatf("result transfer %0d-%0d-%0d with nothing outstanding",
                                 year, month, day));
        end else begin
          want = expected_dates.pop_front();
          check_field("year", 32'(year), 32'(want.year), want.secs);
          check_field("month", 32'(month), 32'(want.month), want.secs);
          check_field("day", 32'(day), 32'(want.day), want.secs);
          check_field("hour", 32'(hour), 32'(want.hour), want.secs);
          check_field("minute", 32'(minute), 32'(want.minute), want.secs);
          check_field("second", 32'(second), 32'(want.second), want.secs);
          check_field("before_epoch", 32'(before_epoch), 32'(want.before_epoch), want.secs);
        end
      end
    end
    pending  <= expected_dates.size();
    failures <= fail_total;
  end

endmodule

// ----- sim/unix_seconds_to_calendar_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the testbench for unix_seconds_to_calendar_unit: drives input transfers and result
// stalls with random gaps and gives the verdict. Depends on usc_pkg and the checker module.
module unix_seconds_to_calendar_unit_tb;

  localparam int unsigned RandomItems = 600;
  localparam int unsigned LastDay     = 38752;
  localparam int unsigned HoldAt      = 2000;
  localparam int unsigned HoldLen     = 600;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [31:0] unix_seconds = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        before_epoch;
  int unsigned failures;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned early_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  unix_seconds_to_calendar_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .unix_seconds (unix_seconds),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .before_epoch (before_epoch)
  );

  unix_seconds_to_calendar_check checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .unix_seconds (unix_seconds),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .before_epoch (before_epoch),
    .failures     (failures),
    .pending      (pending)
  );

  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic [31:0] secs_of(input int unsigned days, input int unsigned tod);
    return usc_pkg::SecsTo2000 + days * usc_pkg::SecsPerDay + tod;
  endfunction

  task automatic send_item(input logic [31:0] secs);
    int unsigned gap;
    item_valid   <= 1'b1;
    unix_seconds <= secs;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (secs < usc_pkg::SecsTo2000) early_sent++;
    gap = gap_length();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
      $display("[unix_seconds_to_calendar_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned rx_cycles;
    int unsigned stall_len;
    int unsigned run_len;
    bit          held;
    rx_cycles = 0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && rx_cycles >= HoldAt) begin
        result_stall <= 1'b1;
        repeat (HoldLen) @(posedge clk);
        rx_cycles += HoldLen;
        held = 1'b1;
      end
      stall_len = gap_length();
      if (stall_len != 0) begin
        result_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      run_len = $urandom_range(16, 1);
      result_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      rx_cycles += stall_len + run_len;
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned year_off;
    int unsigned days;
    int unsigned tod;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(32'd0);
    send_item(32'd86399);
    send_item(usc_pkg::SecsTo2000 - 30 * usc_pkg::SecsPerDay + 12345);
    send_item(usc_pkg::SecsTo2000 - 1);
    send_item(usc_pkg::SecsTo2000);
    send_item(secs_of(30, usc_pkg::SecsPerDay - 1));
    send_item(secs_of(31, 0));
    send_item(secs_of(59, 43210));
    send_item(secs_of(60, 0));
    send_item(secs_of(365, usc_pkg::SecsPerDay - 1));
    send_item(secs_of(366, 0));
    send_item(secs_of(424, usc_pkg::SecsPerDay - 1));
    send_item(secs_of(425, 0));
    send_item(secs_of(1460, usc_pkg::SecsPerDay - 1));
    send_item(secs_of(1461, 0));
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    send_item(secs_of(36584, 3723));
    send_item(secs_of(36585, 0));
    send_item(secs_of(36889, usc_pkg::SecsPerDay - 1));
    send_item(32'hFFFF_FFFE);
    send_item(32'hFFFF_FFFF);

    repeat (RandomItems) begin
      kind = $urandom_range(99, 0);
      if (kind < 30) begin
        send_item($urandom);
      end else if (kind < 65) begin
        year_off = $urandom_range(106, 0);
        days = year_off * usc_pkg::DaysPerYear + (year_off + 3) / 4;
        case ($urandom_range(5, 0))
          0: days += 0;
          1: days += 58;
          2: days += 59;
          3: days += 60;
          4: days += usc_pkg::DaysPerYear - ((year_off % 4 == 0) ? 0 : 1);
          default: days += $urandom_range(usc_pkg::DaysPerYear - 1, 0);
        endcase
        if (days > LastDay) days = LastDay;
        case ($urandom_range(2, 0))
          0: tod = 0;
          1: tod = usc_pkg::SecsPerDay - 1;
          default: tod = $urandom_range(usc_pkg::SecsPerDay - 1, 0);
        endcase
        send_item(secs_of(days, tod));
      end else if (kind < 85) begin
        send_item($urandom_range(32'hFFFF_FFFF, usc_pkg::SecsTo2000));
      end else begin
        send_item($urandom_range(usc_pkg::SecsTo2000 - 1, 0));
      end
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d timestamps, %0d of them before 2000, with random gaps on both sides",
             items_sent, early_sent);
    $display("and one %0d-cycle hold-off on the result side.", HoldLen);
    if (failures == 0) begin
      $display("[unix_seconds_to_calendar_unit] OK");
    end else begin
      $display("[unix_seconds_to_calendar_unit] ERROR");
    end
    $finish;
  end

endmodule
